// ===== hdl/sorted_priority_table_unit_defines.svh =====
// Assertion macros for the sorted priority table unit.
// Each macro expects clk and rst_n in scope.
`ifndef SORTED_PRIORITY_TABLE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_TABLE_UNIT_DEFINES_SVH

// Check a condition in every cycle outside reset.
`define SPTU_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sorted priority table: invariant violated");

// Check that a trigger in one cycle is followed by a condition in the next.
`define SPTU_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("sorted priority table: sequence violated");

`endif

// ===== hdl/sptu_pkg.sv =====
package sptu_pkg;

  localparam int KEY_W      = 16;
  localparam int TAG_W      = 8;
  localparam int RANK_W     = 6;
  localparam int CNT_OUT_W  = 7;
  localparam int CAPACITY_D = 64;

  localparam logic ACT_ADMIT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic   ins;
    logic   load;
    logic   shift;
    entry_t ent;
  } cell_ctrl_t;

  typedef struct packed {
    status_t              status;
    logic [TAG_W-1:0]     tag;
    logic [KEY_W-1:0]     health;
    logic [CNT_OUT_W-1:0] cnt;
  } res_t;

endpackage

// ===== hdl/sorted_priority_table_unit.sv =====
// Sorted priority table: a row of cells holding up to CAPACITY entries
// (16-bit key, 8-bit tag) in rising key order; equal keys keep arrival order.
// Input channel in_valid/in_ready carries one request: in_action 0 admits
// in_health_key/in_entry_tag, 1 reads the entry at in_rank. Each request
// yields one result on out_valid/out_ready: status, tag, key, entry count.
// Admit: every cell compares its key with the new one in the same cycle and
// either keeps, shifts up, or takes the new entry; the result goes to the output
// register, or to the holding register while the output stalls.
// Read at rank r: all cells load a read line in parallel, which then moves
// one cell per cycle towards cell zero; the result is formed from cell zero once
// the walk count reaches zero, and no request is taken during the walk.
// Out-of-range reads and admits to a full table answer without a walk.
// A result that the receiver has not taken sits in the output register; a
// second result then waits in a holding register and requests are refused
// until it moves on. Synchronous reset empties the table (count zero) and
// drops any pending result; cell contents are left as they are.
`include "sorted_priority_table_unit_defines.svh"

module sorted_priority_table_unit #(
  parameter int CAPACITY = sptu_pkg::CAPACITY_D
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [sptu_pkg::KEY_W-1:0]       in_health_key,
  input  logic [sptu_pkg::TAG_W-1:0]       in_entry_tag,
  input  logic [sptu_pkg::RANK_W-1:0]      in_rank,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [sptu_pkg::TAG_W-1:0]       out_tag,
  output logic [sptu_pkg::KEY_W-1:0]       out_health,
  output logic [sptu_pkg::CNT_OUT_W-1:0]   out_entry_count
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int RCW = (CW > sptu_pkg::RANK_W) ? CW : sptu_pkg::RANK_W;
  localparam int CXW = (CW > sptu_pkg::CNT_OUT_W) ? CW : sptu_pkg::CNT_OUT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [sptu_pkg::RANK_W-1:0]  walk_cnt_r, walk_cnt_nxt;
  sptu_pkg::res_t               res_r, res_nxt;
  sptu_pkg::res_t               out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         in_fire;
  logic                         out_free;
  logic                         is_admit;
  logic                         full;
  logic                         in_range;
  logic [CXW-1:0]               cnt_x;
  logic [sptu_pkg::CNT_OUT_W-1:0] cnt_out;
  logic                         have_res;
  sptu_pkg::res_t               new_res;
  sptu_pkg::cell_ctrl_t         ctrl;

  sptu_pkg::entry_t             ent_w [CAPACITY];
  sptu_pkg::entry_t             rsp_w [CAPACITY];
  logic                         gt_w  [CAPACITY];

  // Handshake and request decode
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_admit = (in_action == sptu_pkg::ACT_ADMIT);
  assign full     = (count_r == CW'(CAPACITY));
  assign in_range = (RCW'(in_rank) < RCW'(count_r));

  // Drive the cell row
  assign ctrl.ins       = in_fire && is_admit && !full;
  assign ctrl.load      = in_fire && !is_admit && in_range;
  assign ctrl.shift     = (state_r == S_WALK) && (walk_cnt_r != '0);
  assign ctrl.ent.key   = in_health_key;
  assign ctrl.ent.tag   = in_entry_tag;

  assign count_nxt = ctrl.ins ? (count_r + CW'(1)) : count_r;
  assign cnt_x     = CXW'(count_nxt);
  assign cnt_out   = cnt_x[sptu_pkg::CNT_OUT_W-1:0];

  // Row of compare-and-shift cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             occ;
    logic             gt_prev;
    sptu_pkg::entry_t prev_ent;
    sptu_pkg::entry_t rsp_next;

    assign occ = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign gt_prev  = 1'b0;
      assign prev_ent = '0;
    end else begin : g_mid
      assign gt_prev  = gt_w[i-1];
      assign prev_ent = ent_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rsp_next = '0;
    end else begin : g_inner
      assign rsp_next = rsp_w[i+1];
    end

    sptu_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (occ),
      .gt_prev  (gt_prev),
      .prev_ent (prev_ent),
      .rsp_next (rsp_next),
      .ent_o    (ent_w[i]),
      .gt_o     (gt_w[i]),
      .rsp_o    (rsp_w[i])
    );
  end

  // Sequencer: form results, walk the read line, hold a stalled result
  always_comb begin
    state_nxt     = state_r;
    walk_cnt_nxt  = walk_cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    have_res      = 1'b0;
    new_res       = '0;
    new_res.cnt   = cnt_out;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_admit) begin
            have_res       = 1'b1;
            new_res.status = full ? sptu_pkg::ST_FULL : sptu_pkg::ST_OK;
          end else if (in_range) begin
            walk_cnt_nxt = in_rank;
            state_nxt    = S_WALK;
          end else begin
            have_res       = 1'b1;
            new_res.status = sptu_pkg::ST_RANGE;
          end
        end
      end
      S_WALK: begin
        if (walk_cnt_r == '0) begin
          have_res       = 1'b1;
          new_res.status = sptu_pkg::ST_OK;
          new_res.tag    = rsp_w[0].tag;
          new_res.health = rsp_w[0].key;
        end else begin
          walk_cnt_nxt = walk_cnt_r - sptu_pkg::RANK_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Send a fresh result straight out, or park it while the output stalls
    if (have_res) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_nxt       = new_res;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = new_res;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      walk_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_tag         = out_r.tag;
  assign out_health      = out_r.health;
  assign out_entry_count = out_r.cnt;

  // Checks
  `SPTU_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY))
  `SPTU_NEXT(a_admit_grows, in_fire && is_admit && !full, count_r == $past(count_r) + CW'(1))
  `SPTU_NEXT(a_count_still, !(in_fire && is_admit), $stable(count_r))
  `SPTU_NEXT(a_read_walks, in_fire && !is_admit && in_range, state_r == S_WALK)
  `SPTU_ALWAYS(a_park_only_stalled, (state_r != S_DONE) || out_valid_r)

endmodule

// ===== hdl/sptu_cell.sv =====
module sptu_cell (
  input  logic                  clk,
  input  sptu_pkg::cell_ctrl_t  ctrl,
  input  logic                  occ,
  input  logic                  gt_prev,
  input  sptu_pkg::entry_t      prev_ent,
  input  sptu_pkg::entry_t      rsp_next,
  output sptu_pkg::entry_t      ent_o,
  output logic                  gt_o,
  output sptu_pkg::entry_t      rsp_o
);

  sptu_pkg::entry_t ent_r, ent_nxt;
  sptu_pkg::entry_t rsp_r, rsp_nxt;

  // An empty cell counts as holding a larger key
  assign gt_o = !occ || (ent_r.key > ctrl.ent.key);

  // Take the neighbour's entry, take the new entry, or hold
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins) begin
      if (gt_prev) begin
        ent_nxt = prev_ent;
      end else if (gt_o) begin
        ent_nxt = ctrl.ent;
      end
    end
  end

  // Load the read line in parallel, then advance it towards cell zero
  always_comb begin
    rsp_nxt = rsp_r;
    if (ctrl.load) begin
      rsp_nxt = ent_r;
    end else if (ctrl.shift) begin
      rsp_nxt = rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    rsp_r <= rsp_nxt;
  end

  assign ent_o = ent_r;
  assign rsp_o = rsp_r;

endmodule

// ===== tb/sorted_priority_table_unit_tb.sv =====
module sorted_priority_table_unit_tb;
  import sptu_pkg::*;

  localparam int CLOCK_LIMIT     = 1000000;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int DRAIN_CYCLES    = 80;
  localparam int HOLD_AT_RESULT  = 300;
  localparam int HOLD_CYCLES     = 400;

  // Mirror of the table: predicts each answer and checks the block against it
  class table_scoreboard;
    logic [KEY_W-1:0] sorted_keys [CAPACITY_D];
    logic [TAG_W-1:0] sorted_tags [CAPACITY_D];
    int unsigned      held;
    res_t             awaited_answers [$];
    int               errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its answer
    function void note_request(logic act, logic [KEY_W-1:0] key,
                               logic [TAG_W-1:0] tag, logic [RANK_W-1:0] rank);
      res_t        ans;
      int unsigned pos;
      ans.status = ST_OK;
      ans.tag    = '0;
      ans.health = '0;
      if (act == ACT_ADMIT) begin
        if (held >= CAPACITY_D) begin
          ans.status = ST_FULL;
        end else begin
          // shift strictly larger keys up; equal keys stay ahead of the newcomer
          pos = held;
          while (pos > 0 && sorted_keys[pos-1] > key) begin
            sorted_keys[pos] = sorted_keys[pos-1];
            sorted_tags[pos] = sorted_tags[pos-1];
            pos--;
          end
          sorted_keys[pos] = key;
          sorted_tags[pos] = tag;
          held++;
        end
      end else if (rank < held) begin
        ans.tag    = sorted_tags[rank];
        ans.health = sorted_keys[rank];
      end else begin
        ans.status = ST_RANGE;
      end
      ans.cnt = CNT_OUT_W'(held);
      awaited_answers.push_back(ans);
    endfunction

    // Compare one accepted result with the oldest queued answer
    function void check_result(logic [1:0] st, logic [TAG_W-1:0] tag,
                               logic [KEY_W-1:0] health, logic [CNT_OUT_W-1:0] cnt);
      res_t want;
      if (awaited_answers.size() == 0) begin
        $display("%0t: result with no request pending: status %0d tag %0h key %0h count %0d",
                 $time, st, tag, health, cnt);
        errors++;
        return;
      end
      want = awaited_answers.pop_front();
      if (2'(want.status) !== st) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (want.tag !== tag) begin
        $display("%0t: tag expected %0h actual %0h", $time, want.tag, tag);
        errors++;
      end
      if (want.health !== health) begin
        $display("%0t: key expected %0h actual %0h", $time, want.health, health);
        errors++;
      end
      if (want.cnt !== cnt) begin
        $display("%0t: count expected %0d actual %0d", $time, want.cnt, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_action;
  logic [KEY_W-1:0]     in_health_key;
  logic [TAG_W-1:0]     in_entry_tag;
  logic [RANK_W-1:0]    in_rank;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [TAG_W-1:0]     out_tag;
  logic [KEY_W-1:0]     out_health;
  logic [CNT_OUT_W-1:0] out_entry_count;

  table_scoreboard book;
  bit              burst_mode = 1'b0;
  int              cycle_count = 0;

  sorted_priority_table_unit #(
    .CAPACITY(CAPACITY_D)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_health_key  (in_health_key),
    .in_entry_tag   (in_entry_tag),
    .in_rank        (in_rank),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_tag        (out_tag),
    .out_health     (out_health),
    .out_entry_count(out_entry_count)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a run that reaches the clock limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CLOCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(input logic act, input logic [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag, input logic [RANK_W-1:0] rank);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_health_key <= key;
    in_entry_tag  <= tag;
    in_rank       <= rank;
    do @(posedge clk); while (!in_ready);
    book.note_request(act, key, tag, rank);
  endtask

  // Favour keys at both ends so that equal keys pile up
  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 2))
      0: return KEY_W'($urandom_range(0, 3));
      1: return KEY_W'(16'hFFFC + $urandom_range(0, 3));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Request side: reset, directed requests, then random traffic and drain
  initial begin
    logic [RANK_W-1:0] pick;
    book          = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_ADMIT;
    in_health_key <= '0;
    in_entry_tag  <= '0;
    in_rank       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: every read is out of range
    send_request(ACT_READ, 16'h0000, 8'h00, 6'd0);
    send_request(ACT_READ, 16'hFFFF, 8'hFF, 6'd63);
    // extreme keys and tags, equal keys in arrival order
    send_request(ACT_ADMIT, 16'hFFFF, 8'hFF, 6'd63);
    send_request(ACT_ADMIT, 16'h0000, 8'h00, 6'd0);
    send_request(ACT_ADMIT, 16'h8000, 8'h55, 6'd21);
    send_request(ACT_ADMIT, 16'h8000, 8'hAA, 6'd42);
    send_request(ACT_ADMIT, 16'h0000, 8'h01, 6'd0);
    send_request(ACT_ADMIT, 16'hFFFF, 8'h7F, 6'd63);
    // walk every held rank, then one at the count and the top rank
    for (int r = 0; r < 6; r++) begin
      send_request(ACT_READ, 16'h0000, 8'h00, RANK_W'(r));
    end
    send_request(ACT_READ, 16'hFFFF, 8'hFF, 6'd6);
    send_request(ACT_READ, 16'h1234, 8'h5A, 6'd63);

    // random traffic: sparse admits fill the table, then admits bounce off
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      burst_mode = (i >= 900 && i < 1100);
      if ($urandom_range(0, 11) == 0) begin
        send_request(ACT_ADMIT, draw_key(), TAG_W'($urandom), RANK_W'($urandom));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          pick = RANK_W'($urandom);
        end else begin
          pick = RANK_W'($urandom_range(0, (book.held > 63) ? 63 : book.held));
        end
        send_request(ACT_READ, KEY_W'($urandom), TAG_W'($urandom), pick);
      end
    end
    in_valid <= 1'b0;
    burst_mode = 1'b0;

    // drain outstanding answers, then watch for stray results
    while (book.awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.awaited_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int gap;
    int taken;
    out_ready <= 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (taken == HOLD_AT_RESULT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      book.check_result(out_status, out_tag, out_health, out_entry_count);
      taken++;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sptu_pkg.sv
hdl/sptu_cell.sv
hdl/sorted_priority_table_unit.sv
tb/sorted_priority_table_unit_tb.sv
